// File: rtl/assert_macros.svh
// Concurrent assertion macros used by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked under reset gating.
`define MSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msm assertion failed");
// Checked at every edge, reset included.
`define MSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("msm assertion failed");
`else
`define MSM_ASSERT(lbl, clk, rst_n, prop)
`define MSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/msm_pkg.sv
// Shared types and constants of the Markov next-state sampler.
`default_nettype none

package msm_pkg;

    localparam int STATE_W  = 6;
    localparam int CHANCE_W = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam int MAX_STATES_DEF  = 64;
    localparam int MAX_NEUTRAL_DEF = 8;

    // bad_chance * scaling, Q0.16 x Q8.8
    localparam int PROD_W     = 2 * CHANCE_W;
    localparam int FRAC_SHIFT = 8;
    localparam int SCALED_W   = PROD_W - FRAC_SHIFT;
    // reciprocal divide: exact for dividends below 2^24 and divisors up to 32
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    // running total of the walk, signed, never overflows
    localparam int TOTAL_W = 32;

    // depth of the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_BAD     = 2'd0,
        CMD_NEUTRAL = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DUP  = 2'd1,
        STAT_ROW_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_SCALE,
        ST_DIV,
        ST_SHARE,
        ST_WALK,
        ST_OUT
    } t_state;

    // classified item; row already reduced modulo the state count
    typedef struct packed {
        t_cmd                cmd;
        logic [STATE_W-1:0]  row;
        logic [STATE_W-1:0]  target;
        logic [CHANCE_W-1:0] chance;
        logic [CHANCE_W-1:0] rnd;
        logic [CHANCE_W-1:0] scaling;
    } t_job;

    typedef struct packed {
        logic [STATE_W-1:0]  target;
        logic [CHANCE_W-1:0] chance;
    } t_entry;

    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// File: rtl/msm_if.sv
// Valid/ready channel interfaces for the sampler's input and result streams.
`default_nettype none

interface msm_in_if;
    import msm_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [STATE_W-1:0]  state_index;
    logic [STATE_W-1:0]  target;
    logic [CHANCE_W-1:0] chance;
    logic [CHANCE_W-1:0] random_value;
    logic [CHANCE_W-1:0] scaling;

    modport source (
        output valid, command, state_index, target, chance, random_value, scaling,
        input  ready
    );
    modport sink (
        input  valid, command, state_index, target, chance, random_value, scaling,
        output ready
    );
endinterface

interface msm_out_if;
    import msm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATE_W-1:0]  next_state;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, next_state, status,
        input  ready
    );
    modport sink (
        input  valid, next_state, status,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/msm_queue.sv
// Short job queue between the front and back of the sampler.
`default_nettype none

module msm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  msm_pkg::t_job    i_job,
    input  logic             i_pop,
    output msm_pkg::t_job    o_head,
    output msm_pkg::t_q_stat o_stat
);
    import msm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_head            = r_slot[r_rd_ptr];
    assign o_stat.head_valid = (r_cnt != '0);
    assign o_stat.full       = (r_cnt == NW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: rtl/msm_front.sv
// Input stage: takes items, decodes the command and reduces the row index.
`default_nettype none

module msm_front #(
    parameter int MAX_STATES = msm_pkg::MAX_STATES_DEF
) (
    msm_in_if.sink           i_in,
    input  msm_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output msm_pkg::t_job    o_job
);
    import msm_pkg::*;

    localparam int IDX_N = 1 << STATE_W;

    // index modulo MAX_STATES, built at elaboration
    logic [STATE_W-1:0] w_row_tbl [IDX_N];

    for (genvar g = 0; g < IDX_N; g++) begin : g_row_tbl
        localparam logic [STATE_W-1:0] ROW = STATE_W'(g % MAX_STATES);
        assign w_row_tbl[g] = ROW;
    end

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    always_comb begin
        o_job.cmd     = t_cmd'(i_in.command);
        o_job.row     = w_row_tbl[i_in.state_index];
        o_job.target  = i_in.target;
        o_job.chance  = i_in.chance;
        o_job.rnd     = i_in.random_value;
        o_job.scaling = i_in.scaling;
    end

endmodule

`default_nettype wire

// File: rtl/msm_back.sv
// Execution engine: table memories, bad-chance scaling, share divide and row walk.
`default_nettype none
`include "assert_macros.svh"

module msm_back #(
    parameter int MAX_STATES  = msm_pkg::MAX_STATES_DEF,
    parameter int MAX_NEUTRAL = msm_pkg::MAX_NEUTRAL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msm_pkg::t_q_stat i_q_stat,
    input  msm_pkg::t_job    i_head,
    output logic             o_pop,
    msm_out_if.source        o_out
);
    import msm_pkg::*;

    localparam int RW      = $clog2(MAX_STATES);
    localparam int CW      = $clog2(MAX_NEUTRAL + 1);
    localparam int KW      = (MAX_NEUTRAL > 1) ? $clog2(MAX_NEUTRAL) : 1;
    localparam int ND      = MAX_STATES * MAX_NEUTRAL;
    localparam int AW      = $clog2(ND);
    localparam int QPROD_W = SCALED_W + RECIP_W;

    typedef struct packed {
        logic                bad_valid;
        logic [STATE_W-1:0]  bad_target;
        logic [CHANCE_W-1:0] bad_chance;
        logic [CW-1:0]       count;
    } t_row;

    // storage
    t_row   r_row_mem [MAX_STATES];
    t_entry r_nb_mem  [ND];

    // control and datapath registers
    t_state                r_state, n_state;
    t_job                  r_job;
    t_row                  r_rowq;
    t_entry                r_nq;
    logic [RW-1:0]         r_clr, n_clr;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic signed [TOTAL_W-1:0] r_total, n_total;
    logic [SCALED_W-1:0]   r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [QPROD_W-1:0]    r_qprod, n_qprod;
    logic signed [TOTAL_W-1:0] r_share, n_share;
    logic [KW-1:0]         r_k, n_k;
    logic [STATE_W-1:0]    r_res_next, n_res_next;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [STATE_W-1:0]    r_out_next, n_out_next;
    t_status               r_out_status, n_out_status;

    // strobes and helpers
    logic                  w_pop;
    logic                  w_row_we;
    logic [RW-1:0]         w_row_waddr;
    t_row                  w_row_wdata;
    logic                  w_nb_we;
    logic [AW-1:0]         w_nb_waddr;
    t_entry                w_nb_wdata;
    logic [KW-1:0]         w_rd_k;
    logic [AW-1:0]         w_nb_raddr;
    logic [RW-1:0]         w_row;
    logic [AW-1:0]         w_base;
    logic [SCALED_W-1:0]   w_scaled;
    logic [SCALED_W-1:0]   w_rnd_ext;
    logic signed [SCALED_W:0] w_diff;
    logic [SCALED_W-1:0]   w_qmag;
    logic signed [TOTAL_W-1:0] w_sum;
    logic signed [TOTAL_W-1:0] w_rnd_s;
    logic                  w_dup;
    logic                  w_row_full;
    logic                  w_empty;
    logic                  w_bad_hit;
    logic                  w_last;
    logic                  w_stop;
    logic                  w_slot_free;
    logic [RECIP_W-1:0]    w_recip [MAX_NEUTRAL + 1];

    // ceil(2^RECIP_SHIFT / n) for each possible neutral count
    assign w_recip[0] = '0;
    for (genvar g = 1; g <= MAX_NEUTRAL; g++) begin : g_recip
        localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((64'd1 << RECIP_SHIFT) + g - 1) / g);
        assign w_recip[g] = RECIP;
    end

    assign w_row       = RW'(r_job.row);
    assign w_base      = AW'(w_row) * AW'(MAX_NEUTRAL);
    assign w_nb_raddr  = w_base + AW'(w_rd_k);
    assign w_scaled    = r_prod[PROD_W-1:FRAC_SHIFT];
    assign w_rnd_ext   = SCALED_W'(r_job.rnd);
    assign w_diff      = $signed({1'b0, SCALED_W'(r_rowq.bad_chance)})
                       - $signed({1'b0, w_scaled});
    assign w_qmag      = r_qprod[RECIP_SHIFT +: SCALED_W];
    assign w_rnd_s     = $signed(TOTAL_W'(r_job.rnd));
    assign w_sum       = r_total + $signed(TOTAL_W'(r_nq.chance)) + r_share;
    assign w_dup       = r_rowq.bad_valid;
    assign w_row_full  = (r_rowq.count >= CW'(MAX_NEUTRAL));
    assign w_empty     = (r_rowq.count == '0);
    assign w_bad_hit   = r_rowq.bad_valid && (w_rnd_ext < w_scaled);
    assign w_last      = ((CW'(r_k) + CW'(1)) >= r_rowq.count);
    assign w_stop      = (w_sum >= w_rnd_s) || w_last;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == RW'(MAX_STATES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_stat.head_valid) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (r_job.cmd == CMD_QUERY && !w_empty) begin
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_SCALE: begin
                n_state = w_bad_hit ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                n_state = ST_SHARE;
            end
            ST_SHARE: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_stop) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and strobes
    always_comb begin
        n_clr        = r_clr;
        n_prod       = r_prod;
        n_total      = r_total;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_qprod      = r_qprod;
        n_share      = r_share;
        n_k          = r_k;
        n_res_next   = r_res_next;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_next   = r_out_next;
        n_out_status = r_out_status;
        w_pop        = 1'b0;
        w_row_we     = 1'b0;
        w_row_waddr  = w_row;
        w_row_wdata  = r_rowq;
        w_nb_we      = 1'b0;
        w_nb_waddr   = w_base + AW'(r_rowq.count);
        w_nb_wdata   = '{target: r_job.target, chance: r_job.chance};
        w_rd_k       = '0;

        case (r_state)
            ST_CLEAR: begin
                w_row_we    = 1'b1;
                w_row_waddr = r_clr;
                w_row_wdata = '0;
                n_clr       = r_clr + 1'b1;
            end
            ST_IDLE: begin
                w_pop = i_q_stat.head_valid;
            end
            ST_ROW: begin
                n_res_next   = '0;
                n_res_status = STAT_OK;
                n_prod       = PROD_W'(r_rowq.bad_chance) * PROD_W'(r_job.scaling);
                case (r_job.cmd)
                    CMD_BAD: begin
                        if (w_dup) begin
                            n_res_status = STAT_BAD_DUP;
                        end else begin
                            w_row_we               = 1'b1;
                            w_row_wdata.bad_valid  = 1'b1;
                            w_row_wdata.bad_target = r_job.target;
                            w_row_wdata.bad_chance = r_job.chance;
                        end
                    end
                    CMD_NEUTRAL: begin
                        if (w_row_full) begin
                            n_res_status = STAT_ROW_FULL;
                        end else begin
                            w_nb_we           = 1'b1;
                            w_row_we          = 1'b1;
                            w_row_wdata.count = r_rowq.count + 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        // empty neutral row: bad entry acts alone, else stay put
                        if (r_rowq.bad_valid) begin
                            n_res_next = r_rowq.bad_target;
                        end else begin
                            n_res_next = r_job.row;
                        end
                    end
                    default: begin
                        n_res_next = '0;
                    end
                endcase
            end
            ST_SCALE: begin
                n_res_next = r_rowq.bad_target;
                if (r_rowq.bad_valid) begin
                    n_total = $signed(TOTAL_W'(w_scaled));
                    n_neg   = w_diff[SCALED_W];
                    n_mag   = w_diff[SCALED_W] ? SCALED_W'(-w_diff) : SCALED_W'(w_diff);
                end else begin
                    n_total = '0;
                    n_neg   = 1'b0;
                    n_mag   = '0;
                end
            end
            ST_DIV: begin
                // magnitude / count by reciprocal, truncated toward zero
                n_qprod = QPROD_W'(r_mag) * QPROD_W'(w_recip[r_rowq.count]);
            end
            ST_SHARE: begin
                n_share = r_neg ? -$signed(TOTAL_W'(w_qmag)) : $signed(TOTAL_W'(w_qmag));
                n_k     = '0;
                w_rd_k  = '0;
            end
            ST_WALK: begin
                n_total    = w_sum;
                n_res_next = r_nq.target;
                w_rd_k     = r_k + 1'b1;
                if (!w_stop) begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_OUT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_next   = r_res_next;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= n_prod;
        r_total      <= n_total;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_qprod      <= n_qprod;
        r_share      <= n_share;
        r_k          <= n_k;
        r_res_next   <= n_res_next;
        r_res_status <= n_res_status;
        r_out_next   <= n_out_next;
        r_out_status <= n_out_status;
        if (w_pop) begin
            r_job <= i_head;
        end
    end

    // row memory: one write port, one registered read at pop
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            r_row_mem[w_row_waddr] <= w_row_wdata;
        end
        if (w_pop) begin
            r_rowq <= r_row_mem[RW'(i_head.row)];
        end
    end

    // neutral entry memory
    always_ff @(posedge i_clk) begin
        if (w_nb_we) begin
            r_nb_mem[w_nb_waddr] <= w_nb_wdata;
        end
        r_nq <= r_nb_mem[w_nb_raddr];
    end

    assign o_pop            = w_pop;
    assign o_out.valid      = r_out_valid;
    assign o_out.next_state = r_out_next;
    assign o_out.status     = r_out_status;

    `MSM_ASSERT(a_walk_in_row, i_clk, i_rst_n, (r_state == ST_WALK) |-> (CW'(r_k) < r_rowq.count))
    `MSM_ASSERT(a_no_pop_clear, i_clk, i_rst_n, (r_state == ST_CLEAR) |-> !w_pop)
    `MSM_ASSERT(a_share_nonempty, i_clk, i_rst_n, (r_state == ST_SHARE) |-> !w_empty)
    `MSM_ASSERT(a_out_load, i_clk, i_rst_n, (r_state == ST_OUT && w_slot_free) |=> r_out_valid)

endmodule

`default_nettype wire

// File: rtl/markov_next_state_sampler.sv
// Top level of the Markov next-state sampler.
`default_nettype none

// Roulette-wheel next-state sampler over a per-state transition table. Each
// input item is a bad-entry write, a neutral-entry append or a query, and
// produces exactly one result (next_state, status) in order. After reset the
// block clears every row of its row table before it takes work;
// items still queue up at the input during that sweep. A write passes from the
// queue head through the row read to the result register, as does a query of a
// row with no neutral entries; a query scales the bad chance and ends when the bad
// entry is chosen, and otherwise divides the bad-chance change into shares and walks
// 1 to MAX_NEUTRAL neutral entries, one entry per cycle, through the neutral entry memory.
// A two-deep queue decouples input acceptance from execution, and the result
// register lets the next item start while a result waits to be taken.
module markov_next_state_sampler #(
    parameter int MAX_STATES  = msm_pkg::MAX_STATES_DEF,
    parameter int MAX_NEUTRAL = msm_pkg::MAX_NEUTRAL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msm_in_if.sink     i_in,
    msm_out_if.source  o_out
);
    import msm_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_q_stat w_q_stat;

    msm_front #(
        .MAX_STATES (MAX_STATES)
    ) u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    msm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    msm_back #(
        .MAX_STATES  (MAX_STATES),
        .MAX_NEUTRAL (MAX_NEUTRAL)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
